// ===== sv/slpm_pkg.sv =====
// ----------------------------------------------------------------------------
// slpm_pkg
// Types and codes shared by the LIKE pattern matcher and its channels.
// ----------------------------------------------------------------------------
package slpm_pkg;

    typedef enum logic [2:0] {
        REQ_CLEAR   = 3'd0,
        REQ_ELEMENT = 3'd1,
        REQ_RANGE   = 3'd2,
        REQ_BYTE    = 3'd3,
        REQ_END     = 3'd4
    } req_code_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       is_percent;
        logic       negate;
        logic [7:0] range_low;
        logic [7:0] range_high;
        logic [7:0] value_byte;
    } item_t;

    typedef struct packed {
        logic matched;
        logic pattern_error;
    } result_t;

    // Pattern load command broadcast to every matcher cell
    typedef struct packed {
        logic       new_elem;
        logic       add_range;
        logic       is_percent;
        logic       negate;
        logic [7:0] range_low;
        logic [7:0] range_high;
    } cell_wr_t;

endpackage

// ===== sv/slpm_chan_if.sv =====
// ----------------------------------------------------------------------------
// slpm_chan_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface slpm_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sql_like_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// sql_like_pattern_matcher - LIKE pattern NFA, one request per cycle.
// Result path: a request is taken into the input register; for an end of
// value, its result is then written to the result register.
// Throughput: 1 request per cycle; stalls only while a result waits unread.
// Reset: empty pattern, error flag low, only the start position active.
// ----------------------------------------------------------------------------
module sql_like_pattern_matcher #(
    parameter int MAX_ELEMENTS = 32,
    parameter int MAX_RANGES   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    slpm_chan_if.sink   item,
    slpm_chan_if.source result
);
    import slpm_pkg::*;

    // Positions 0..MAX_ELEMENTS; position i means "first i elements matched"
    localparam int NP = MAX_ELEMENTS + 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int LV = $clog2(NP);

    // ---------------- input register ----------------
    logic    s1_valid_reg, s1_valid_next;
    item_t   s1_item_reg;
    logic    s1_go;
    logic    is_clear, is_elem, is_range, is_byte, is_end;

    // ---------------- pattern / matcher state ----------------
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [NP-1:0] act_reg, act_next;

    // ---------------- result register ----------------
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    logic    out_free;

    // ---------------- cell array wiring ----------------
    cell_wr_t                cell_wr;
    logic [MAX_ELEMENTS-1:0] cell_pct, cell_hit, cell_full;
    logic [MAX_ELEMENTS-1:0] sel_new, sel_range, elem_valid;
    logic                    elem_full, last_full, range_ok;

    // ---------------- closure and step ----------------
    logic [NP-1:0] kg [LV+1];
    logic [NP-1:0] kp [LV+1];
    logic [NP-1:0] closed;
    logic [NP-1:0] step_next;
    logic          matched;

    // Request decode
    always_comb
    begin
        is_clear = 1'b0;
        is_elem  = 1'b0;
        is_range = 1'b0;
        is_byte  = 1'b0;
        is_end   = 1'b0;
        unique case (s1_item_reg.req_type)
            REQ_CLEAR:   is_clear = 1'b1;
            REQ_ELEMENT: is_elem  = 1'b1;
            REQ_RANGE:   is_range = 1'b1;
            REQ_BYTE:    is_byte  = 1'b1;
            REQ_END:     is_end   = 1'b1;
            default:     ;                 // unused codes are dropped silently
        endcase
    end

    // The held request leaves the input register unless it is an end of value
    // and the result register is still occupied.
    assign out_free      = !out_valid_reg || result.ready;
    assign s1_go         = s1_valid_reg && (!is_end || out_free);
    assign item.ready    = !s1_valid_reg || s1_go;
    assign s1_valid_next = item.valid ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            s1_item_reg <= item.data;
    end

    // ---------------- matcher cells ----------------
    // Element writes go to cell count; range writes to the last element.
    assign elem_full = (count_reg >= CW'(MAX_ELEMENTS));
    assign last_full = |(sel_range & cell_full);
    assign range_ok  = (count_reg != '0) && !last_full;

    always_comb
    begin
        cell_wr.new_elem   = s1_go && is_elem && !elem_full;
        cell_wr.add_range  = s1_go && is_range && range_ok;
        cell_wr.is_percent = s1_item_reg.is_percent;
        cell_wr.negate     = s1_item_reg.negate;
        cell_wr.range_low  = s1_item_reg.range_low;
        cell_wr.range_high = s1_item_reg.range_high;
    end

    for (genvar g = 0; g < MAX_ELEMENTS; g++)
    begin : g_cell
        assign sel_new[g]    = (count_reg == CW'(g));
        assign sel_range[g]  = (count_reg == CW'(g + 1));
        assign elem_valid[g] = (count_reg > CW'(g));

        slpm_cell #(
            .MAX_RANGES (MAX_RANGES)
        ) u_cell (
            .clk        (clk),
            .wr         (cell_wr),
            .sel_new    (sel_new[g]),
            .sel_range  (sel_range[g]),
            .value_byte (s1_item_reg.value_byte),
            .pct        (cell_pct[g]),
            .hit        (cell_hit[g]),
            .full       (cell_full[g])
        );
    end

    // ---------------- percent closure ----------------
    // A percent run matches zero bytes, so an active position before a loaded
    // percent element also activates the one after it. This is a carry chain
    // (generate = active, propagate = percent), resolved as a parallel prefix.
    always_comb
    begin
        kg[0]    = act_reg;
        kp[0]    = '0;
        for (int j = 1; j < NP; j++)
            kp[0][j] = elem_valid[j-1] && cell_pct[j-1];
        for (int k = 0; k < LV; k++)
        begin
            for (int j = 0; j < NP; j++)
            begin
                if (j >= (1 << k))
                begin
                    kg[k+1][j] = kg[k][j] || (kp[k][j] && kg[k][j-(1<<k)]);
                    kp[k+1][j] = kp[k][j] && kp[k][j-(1<<k)];
                end
                else
                begin
                    kg[k+1][j] = kg[k][j];
                    kp[k+1][j] = kp[k][j];
                end
            end
        end
    end

    assign closed = kg[LV];

    // ---------------- byte step ----------------
    // Percent cells keep their position; class cells advance on a hit.
    always_comb
    begin
        step_next = '0;
        for (int j = 0; j < NP; j++)
        begin
            if (j < MAX_ELEMENTS)
            begin
                if (closed[j] && elem_valid[j] && cell_pct[j])
                    step_next[j] = 1'b1;
            end
            if (j > 0)
            begin
                if (closed[j-1] && elem_valid[j-1] && !cell_pct[j-1] && cell_hit[j-1])
                    step_next[j] = 1'b1;
            end
        end
    end

    // Whole-pattern match: the position just past the last loaded element
    always_comb
    begin
        matched = 1'b0;
        for (int j = 0; j < NP; j++)
        begin
            if (count_reg == CW'(j))
                matched = closed[j];
        end
    end

    // ---------------- state update ----------------
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        act_next   = act_reg;
        if (s1_go)
        begin
            if (is_clear)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                act_next   = NP'(1);
            end
            if (is_elem)
            begin
                if (elem_full)
                    ovf_next = 1'b1;
                else
                    count_next = count_reg + CW'(1);
            end
            if (is_range && !range_ok)
                ovf_next = 1'b1;
            if (is_byte)
                act_next = step_next;
            if (is_end)
                act_next = NP'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            act_reg   <= NP'(1);
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            act_reg   <= act_next;
        end
    end

    // ---------------- result register ----------------
    assign out_valid_next = (s1_go && is_end) ? 1'b1 :
                            (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && is_end)
        begin
            out_data_reg.matched       <= matched;
            out_data_reg.pattern_error <= ovf_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && is_clear) |=> (count_reg == '0 && !ovf_reg && act_reg == NP'(1)))
        else $error("clear did not reset the pattern");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && is_end) |=> (out_valid_reg && act_reg == NP'(1)))
        else $error("end of value did not post a result and restart");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !(s1_go && is_end))
        else $error("result overwritten while pending");

endmodule

// ===== sv/slpm_cell.sv =====
// ----------------------------------------------------------------------------
// slpm_cell
// One pattern element: stores its class ranges and tests the current byte.
// ----------------------------------------------------------------------------
module slpm_cell #(
    parameter int MAX_RANGES = 4
) (
    input  logic              clk,
    input  slpm_pkg::cell_wr_t wr,
    input  logic              sel_new,
    input  logic              sel_range,
    input  logic [7:0]        value_byte,
    output logic              pct,
    output logic              hit,
    output logic              full
);
    import slpm_pkg::*;

    localparam int RCW = $clog2(MAX_RANGES + 1);
    localparam int RIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic           pct_reg;
    logic           neg_reg;
    logic [RCW-1:0] rcnt_reg;
    logic [7:0]     lo_reg [MAX_RANGES];
    logic [7:0]     hi_reg [MAX_RANGES];
    logic           any_hit;

    // element storage is undefined until loaded
    always_ff @(posedge clk)
    begin
        if (wr.new_elem && sel_new)
        begin
            pct_reg  <= wr.is_percent;
            neg_reg  <= wr.negate;
            rcnt_reg <= '0;
        end
        else if (wr.add_range && sel_range && !full)
        begin
            lo_reg[rcnt_reg[RIW-1:0]] <= wr.range_low;
            hi_reg[rcnt_reg[RIW-1:0]] <= wr.range_high;
            rcnt_reg                  <= rcnt_reg + RCW'(1);
        end
    end

    always_comb
    begin
        any_hit = 1'b0;
        for (int r = 0; r < MAX_RANGES; r++)
        begin
            if (RCW'(r) < rcnt_reg && lo_reg[r] <= value_byte && value_byte <= hi_reg[r])
                any_hit = 1'b1;
        end
    end

    assign full = (rcnt_reg >= RCW'(MAX_RANGES));
    assign pct  = pct_reg;
    assign hit  = any_hit ^ neg_reg;

endmodule

// ===== test/sql_like_pattern_matcher_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sql_like_pattern_matcher_checker
// Watches both channels of the LIKE matcher, keeps its own pattern store and
// active-position set, and compares every end-of-value result in order.
// ----------------------------------------------------------------------------
module sql_like_pattern_matcher_checker #(
    parameter int MAX_ELEMENTS = 32,
    parameter int MAX_RANGES   = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    slpm_chan_if  item,
    slpm_chan_if  result,
    output int    fail_count,
    output int    pending
);
    import slpm_pkg::*;

    localparam int NP = MAX_ELEMENTS + 1;

    int unsigned           elem_count;
    logic [MAX_ELEMENTS-1:0] elem_pct;
    logic [MAX_ELEMENTS-1:0] elem_neg;
    int unsigned           elem_nr [MAX_ELEMENTS];
    logic [7:0]            bound_lo [MAX_ELEMENTS][MAX_RANGES];
    logic [7:0]            bound_hi [MAX_ELEMENTS][MAX_RANGES];
    logic [MAX_ELEMENTS:0] live;
    logic                  load_err;
    result_t               verdict_q [$];
    int                    mismatches;

    // a percent run can match nothing, so activity falls through it
    function automatic logic [MAX_ELEMENTS:0] percent_closure(
        input logic [MAX_ELEMENTS:0] a
    );
        logic [MAX_ELEMENTS:0] c;
        c = a;
        for (int i = 0; i < elem_count; i++)
            if (c[i] && elem_pct[i])
                c[i+1] = 1'b1;
        return c;
    endfunction

    function automatic logic class_accepts(input int e, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int r = 0; r < elem_nr[e]; r++)
            if (bound_lo[e][r] <= b && b <= bound_hi[e][r])
                hit = 1'b1;
        return elem_neg[e] ? !hit : hit;
    endfunction

    function automatic logic [MAX_ELEMENTS:0] advance_on_byte(input logic [7:0] b);
        logic [MAX_ELEMENTS:0] cur;
        logic [MAX_ELEMENTS:0] nxt;
        cur = percent_closure(live);
        nxt = '0;
        for (int i = 0; i < elem_count; i++)
            if (cur[i])
            begin
                if (elem_pct[i])
                    nxt[i] = 1'b1;
                else if (class_accepts(i, b))
                    nxt[i+1] = 1'b1;
            end
        return nxt;
    endfunction

    task automatic take_request(input item_t it);
        result_t               want;
        logic [MAX_ELEMENTS:0] fin;
        int unsigned           e;
        case (it.req_type)
            REQ_CLEAR:
            begin
                elem_count = 0;
                load_err   = 1'b0;
                live       = NP'(1);
            end
            REQ_ELEMENT:
            begin
                if (elem_count >= MAX_ELEMENTS)
                    load_err = 1'b1;
                else
                begin
                    elem_pct[elem_count] = it.is_percent;
                    elem_neg[elem_count] = it.negate;
                    elem_nr[elem_count]  = 0;
                    elem_count++;
                end
            end
            REQ_RANGE:
            begin
                if (elem_count == 0)
                    load_err = 1'b1;
                else
                begin
                    e = elem_count - 1;
                    if (elem_nr[e] >= MAX_RANGES)
                        load_err = 1'b1;
                    else
                    begin
                        bound_lo[e][elem_nr[e]] = it.range_low;
                        bound_hi[e][elem_nr[e]] = it.range_high;
                        elem_nr[e]++;
                    end
                end
            end
            REQ_BYTE:
                live = advance_on_byte(it.value_byte);
            REQ_END:
            begin
                fin                = percent_closure(live);
                want.matched       = fin[elem_count];
                want.pattern_error = load_err;
                verdict_q.push_back(want);
                live = NP'(1);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (verdict_q.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: unexpected result matched=%0b error=%0b",
                         $realtime, got.matched, got.pattern_error);
            mismatches++;
        end
        else
        begin
            want = verdict_q.pop_front();
            if (got.matched !== want.matched || got.pattern_error !== want.pattern_error)
            begin
                if (mismatches < 10)
                    $display("%0t: result mismatch: expected matched=%0b error=%0b, got matched=%0b error=%0b",
                             $realtime, want.matched, want.pattern_error,
                             got.matched, got.pattern_error);
                mismatches++;
            end
        end
    endtask

    // request first: a result can never belong to a same-edge request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count = 0;
            elem_pct   = '0;
            elem_neg   = '0;
            live       = NP'(1);
            load_err   = 1'b0;
            mismatches = 0;
            foreach (elem_nr[i])
                elem_nr[i] = 0;
            verdict_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (item.valid && item.ready)
                take_request(item.data);
            if (result.valid && result.ready)
                check_result(result.data);
            fail_count <= mismatches;
            pending    <= verdict_q.size();
        end
    end

endmodule

// ===== test/sql_like_pattern_matcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sql_like_pattern_matcher_tb
// Loads LIKE patterns and streams values through the matcher: a directed
// pass over the corner cases, then random patterns with mostly matching
// values, under bursty input and a stalling result side. The checker
// beside the block predicts and compares every end-of-value result.
// ----------------------------------------------------------------------------
module sql_like_pattern_matcher_tb;
    import slpm_pkg::*;

    localparam int MAX_ELEMENTS = 32;
    localparam int MAX_RANGES   = 4;

    // request codes the block must ignore
    localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;

    localparam int ITEM_TARGET   = 1925;   // directed plus random
    localparam int DRAIN_AT      = 1000;   // sender waits for all results here
    localparam int HOLD_AT       = 1500;   // receiver cycle of the long hold-off
    localparam int HOLD_LEN      = 400;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 300000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    slpm_chan_if #(.data_t(item_t))   item_ch ();
    slpm_chan_if #(.data_t(result_t)) result_ch ();

    sql_like_pattern_matcher #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_RANGES   (MAX_RANGES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    sql_like_pattern_matcher_checker #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_RANGES   (MAX_RANGES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shadow of the loaded pattern. Only steers value generation toward
    // matching strings; it plays no part in checking.
    int unsigned gen_len;
    bit          gen_pct [MAX_ELEMENTS];
    int unsigned gen_nr  [MAX_ELEMENTS];
    logic [7:0]  gen_lo  [MAX_ELEMENTS][MAX_RANGES];
    logic [7:0]  gen_hi  [MAX_ELEMENTS][MAX_RANGES];

    int unsigned burst_left;
    int unsigned sent;

    // every field random; callers overwrite the ones the request uses
    function automatic item_t random_item(input logic [2:0] req);
        item_t it;
        it.req_type   = req;
        it.is_percent = 1'($urandom_range(0, 1));
        it.negate     = 1'($urandom_range(0, 1));
        it.range_low  = 8'($urandom_range(0, 255));
        it.range_high = 8'($urandom_range(0, 255));
        it.value_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic item_t new_element(input logic pct, input logic neg);
        item_t it;
        it            = random_item(REQ_ELEMENT);
        it.is_percent = pct;
        it.negate     = neg;
        return it;
    endfunction

    function automatic item_t class_range(input logic [7:0] lo, input logic [7:0] hi);
        item_t it;
        it            = random_item(REQ_RANGE);
        it.range_low  = lo;
        it.range_high = hi;
        return it;
    endfunction

    function automatic item_t value_item(input logic [7:0] b);
        item_t it;
        it            = random_item(REQ_BYTE);
        it.value_byte = b;
        return it;
    endfunction

    // Offer one request and hold it until the transfer. The sender runs in
    // bursts; a gap drops valid for a random number of cycles. Valid stays
    // high between back-to-back requests, so it gets one assignment per edge.
    task automatic offer(input item_t it);
        int unsigned gap;
        case (it.req_type)
            REQ_CLEAR:
                gen_len = 0;
            REQ_ELEMENT:
                if (gen_len < MAX_ELEMENTS)
                begin
                    gen_pct[gen_len] = it.is_percent;
                    gen_nr[gen_len]  = 0;
                    gen_len++;
                end
            REQ_RANGE:
                if (gen_len != 0 && gen_nr[gen_len-1] < MAX_RANGES)
                begin
                    gen_lo[gen_len-1][gen_nr[gen_len-1]] = it.range_low;
                    gen_hi[gen_len-1][gen_nr[gen_len-1]] = it.range_high;
                    gen_nr[gen_len-1]++;
                end
            default: ;
        endcase
        if (it.req_type <= REQ_END)
            sent++;

        if (burst_left == 0)
        begin
            // now and then a long run with no gap at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // Random pattern: mostly short, sometimes long enough to overflow the
    // element store. Classes mix literals, underscores, ordinary and
    // inverted ranges; a few get one range too many.
    task automatic load_pattern();
        int unsigned n_elem;
        int unsigned n_rng;
        int unsigned kind;
        logic [7:0]  a;
        logic [7:0]  b;
        item_t       it;
        // occasionally append to the current pattern instead of clearing
        if ($urandom_range(0, 99) >= 3)
            offer(random_item(REQ_CLEAR));
        n_elem = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 2)
                                             : $urandom_range(0, 6);
        for (int e = 0; e < n_elem; e++)
        begin
            it = new_element($urandom_range(0, 99) < 30, $urandom_range(0, 99) < 20);
            offer(it);
            if (it.is_percent)
                n_rng = ($urandom_range(0, 9) == 0) ? 1 : 0;
            else if ($urandom_range(0, 9) == 0)
                n_rng = MAX_RANGES + 1;
            else
                n_rng = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, MAX_RANGES);
            repeat (n_rng)
            begin
                kind = $urandom_range(0, 9);
                a    = 8'($urandom_range(0, 255));
                b    = 8'($urandom_range(0, 255));
                if (kind < 5)
                    offer(class_range(a, a));
                else if (kind == 5)
                    offer(class_range(8'h00, 8'hFF));
                else if (kind < 9)
                    offer(class_range(a < b ? a : b, a < b ? b : a));
                else
                    offer(class_range(a < b ? b : a, a < b ? a : b));
            end
        end
    endtask

    // A value walked along the shadow pattern so that most values get deep
    // into the matcher, with stray bytes, skipped classes and the rare
    // element added mid value to break some of them.
    task automatic run_value();
        int unsigned reps;
        int unsigned r;
        item_t       it;
        for (int e = 0; e < gen_len; e++)
        begin
            if ($urandom_range(0, 39) == 0)
                offer(random_item(REQ_BYTE));
            if ($urandom_range(0, 49) == 0)
                offer(new_element(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            if (gen_pct[e])
                reps = $urandom_range(0, 3);
            else
                reps = ($urandom_range(0, 19) == 0) ? 0 : 1;
            repeat (reps)
            begin
                it = random_item(REQ_BYTE);
                if (!gen_pct[e] && gen_nr[e] != 0 && $urandom_range(0, 3) != 0)
                begin
                    r = $urandom_range(0, gen_nr[e] - 1);
                    if (gen_lo[e][r] <= gen_hi[e][r])
                        it.value_byte = 8'($urandom_range(gen_lo[e][r], gen_hi[e][r]));
                end
                offer(it);
            end
        end
        offer(random_item(REQ_END));
    endtask

    // Result side: stall modes that change every so often (including
    // never stalling), plus one long hold-off so the result register fills
    // and the block backs up onto its input.
    initial
    begin : receiver
        int unsigned cyc;
        int unsigned mode_left;
        int unsigned stall_pct;
        int unsigned hold_left;
        cyc       = 0;
        mode_left = 0;
        stall_pct = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_AT)
                hold_left = HOLD_LEN;
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned sel;
        bit          drained;
        item_t       it;
        drained       = 1'b0;
        burst_left    = 0;
        sent          = 0;
        gen_len       = 0;
        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // range with no element to attach to, then an empty value
        offer(class_range(8'h00, 8'hFF));
        offer(random_item(REQ_END));
        // clear drops the error; empty value against empty pattern
        offer(random_item(REQ_CLEAR));
        offer(random_item(REQ_END));
        // one class with bounds at both ends, an inverted range, then
        // one range more than a class holds
        offer(new_element(1'b0, 1'b0));
        offer(class_range(8'h00, 8'h00));
        offer(class_range(8'hFF, 8'hFF));
        offer(class_range(8'hC8, 8'h64));
        offer(class_range(8'h80, 8'h80));
        offer(class_range(8'h07, 8'h07));
        offer(value_item(8'hFF));
        offer(random_item(REQ_END));
        // negated percent run carrying a range, a negated empty class
        // (any byte), and a plain empty class (no byte)
        offer(random_item(REQ_CLEAR));
        offer(new_element(1'b1, 1'b1));
        offer(class_range(8'h00, 8'h00));
        offer(new_element(1'b0, 1'b1));
        offer(new_element(1'b0, 1'b0));
        offer(value_item(8'h80));
        offer(random_item(REQ_END));
        // pattern grows while a value is in flight; unknown codes between
        offer(value_item(8'h00));
        offer(new_element(1'b1, 1'b0));
        it          = random_item(REQ_UNKNOWN_FIRST);
        offer(it);
        it.req_type = REQ_UNKNOWN_LAST;
        offer(it);
        offer(random_item(REQ_END));
        offer(random_item(REQ_CLEAR));

        while (sent < ITEM_TARGET)
        begin
            if (!drained && sent >= DRAIN_AT)
            begin
                // hold the input until every result has come back
                drained       = 1'b1;
                burst_left    = 0;
                item_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 8)
                offer(random_item(3'($urandom_range(REQ_CLEAR, REQ_UNKNOWN_LAST))));
            else if (sel < 25)
                load_pattern();
            else
                run_value();
        end

        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // room for any stray result the block might still produce
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/slpm_pkg.sv
sv/slpm_chan_if.sv
sv/slpm_cell.sv
sv/sql_like_pattern_matcher.sv
test/sql_like_pattern_matcher_checker.sv
test/sql_like_pattern_matcher_tb.sv
